>>> rtl/akf_pkg.sv
// Shared constants, micro-op encoding and the filter's update program
// for the angle/gyro fusion block. No dependencies.
`default_nettype none
package akf_pkg;

  localparam int DW = 48;               // data word width
  localparam int FB = 32;               // fraction bits
  localparam int HW = DW / 2;           // multiplier half-word operand width
  localparam int PW = 2 * DW;           // full product width
  localparam int NW = DW + FB;          // divider dividend width

  localparam logic [DW-1:0] ONE  = DW'(1) << FB;
  localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};

  localparam logic [46:0] Q_ANGLE_RST   = 47'd429497;
  localparam logic [46:0] Q_GYRO_RST    = 47'd12884902;
  localparam logic [46:0] R_ANGLE_RST   = 47'd429496730;
  localparam logic [32:0] STEP_TIME_RST = 33'd4294967;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_Q_ANGLE   = 2'd0;
  localparam logic [1:0] REG_Q_GYRO    = 2'd1;
  localparam logic [1:0] REG_R_ANGLE   = 2'd2;
  localparam logic [1:0] REG_STEP_TIME = 2'd3;

  // Micro-op codes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_END = 3'd4;

  // Operand / destination codes
  localparam logic [4:0] R_ANGLE = 5'd0;
  localparam logic [4:0] R_BIAS  = 5'd1;
  localparam logic [4:0] R_C00   = 5'd2;
  localparam logic [4:0] R_C01   = 5'd3;
  localparam logic [4:0] R_C10   = 5'd4;
  localparam logic [4:0] R_C11   = 5'd5;
  localparam logic [4:0] R_ACC   = 5'd6;
  localparam logic [4:0] R_GYR   = 5'd7;
  localparam logic [4:0] R_T     = 5'd8;
  localparam logic [4:0] R_S     = 5'd9;
  localparam logic [4:0] R_U     = 5'd10;
  localparam logic [4:0] R_K0    = 5'd11;
  localparam logic [4:0] R_K1    = 5'd12;
  localparam logic [4:0] R_E     = 5'd13;
  localparam logic [4:0] R_ERR   = 5'd14;
  localparam logic [4:0] R_RATE  = 5'd15;
  localparam logic [4:0] R_QA    = 5'd16;
  localparam logic [4:0] R_QG    = 5'd17;
  localparam logic [4:0] R_RA    = 5'd18;
  localparam logic [4:0] R_DT    = 5'd19;

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_LAST = 5'd30;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] dst;
    logic [4:0] src_a;
    logic [4:0] src_b;
  } uop_t;

  function automatic uop_t prog(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      5'd0:  u = '{OP_SUB, R_T,     R_GYR,   R_BIAS};
      5'd1:  u = '{OP_MUL, R_T,     R_T,     R_DT};
      5'd2:  u = '{OP_ADD, R_ANGLE, R_ANGLE, R_T};
      5'd3:  u = '{OP_MUL, R_U,     R_C11,   R_DT};
      5'd4:  u = '{OP_ADD, R_S,     R_C01,   R_C10};
      5'd5:  u = '{OP_MUL, R_S,     R_S,     R_DT};
      5'd6:  u = '{OP_SUB, R_S,     R_QA,    R_S};
      5'd7:  u = '{OP_MUL, R_T,     R_U,     R_DT};
      5'd8:  u = '{OP_ADD, R_S,     R_S,     R_T};
      5'd9:  u = '{OP_ADD, R_C00,   R_C00,   R_S};
      5'd10: u = '{OP_SUB, R_C01,   R_C01,   R_U};
      5'd11: u = '{OP_SUB, R_C10,   R_C10,   R_U};
      5'd12: u = '{OP_ADD, R_C11,   R_C11,   R_QG};
      5'd13: u = '{OP_ADD, R_E,     R_RA,    R_C00};
      5'd14: u = '{OP_DIV, R_K0,    R_C00,   R_E};
      5'd15: u = '{OP_DIV, R_K1,    R_C10,   R_E};
      5'd16: u = '{OP_SUB, R_ERR,   R_ACC,   R_ANGLE};
      5'd17: u = '{OP_MUL, R_T,     R_K0,    R_ERR};
      5'd18: u = '{OP_ADD, R_ANGLE, R_ANGLE, R_T};
      5'd19: u = '{OP_MUL, R_T,     R_K1,    R_ERR};
      5'd20: u = '{OP_ADD, R_BIAS,  R_BIAS,  R_T};
      5'd21: u = '{OP_SUB, R_RATE,  R_GYR,   R_BIAS};
      // covariance update: use old cov_00 / cov_01 before they change
      5'd22: u = '{OP_MUL, R_T,     R_K1,    R_C00};
      5'd23: u = '{OP_SUB, R_C10,   R_C10,   R_T};
      5'd24: u = '{OP_MUL, R_T,     R_K1,    R_C01};
      5'd25: u = '{OP_SUB, R_C11,   R_C11,   R_T};
      5'd26: u = '{OP_MUL, R_T,     R_K0,    R_C01};
      5'd27: u = '{OP_SUB, R_C01,   R_C01,   R_T};
      5'd28: u = '{OP_MUL, R_T,     R_K0,    R_C00};
      5'd29: u = '{OP_SUB, R_C00,   R_C00,   R_T};
      default: u = '{OP_END, R_T,   R_T,     R_T};
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

>>> rtl/akf_alu.sv
// Saturating add/subtract of two signed data words.
// Depends on akf_pkg.
`default_nettype none
module akf_alu (
  input  wire logic [akf_pkg::DW-1:0] a,
  input  wire logic [akf_pkg::DW-1:0] b,
  input  wire logic                   sub,
  output logic      [akf_pkg::DW-1:0] y
);
  logic [akf_pkg::DW:0] ext_a, ext_b, sum;

  always_comb begin
    ext_a = {a[akf_pkg::DW-1], a};
    ext_b = {b[akf_pkg::DW-1], b};
    sum   = sub ? ext_a - ext_b : ext_a + ext_b;
    if (sum[akf_pkg::DW] != sum[akf_pkg::DW-1]) begin
      // clamp toward the sign of the true result
      y = sum[akf_pkg::DW] ? ~akf_pkg::MAXV : akf_pkg::MAXV;
    end else begin
      y = sum[akf_pkg::DW-1:0];
    end
  end
endmodule
`default_nettype wire

>>> rtl/akf_mul.sv
// Iterative fixed-point multiplier: four half-width partial products,
// then round-to-nearest, shift by the fraction bits and saturate.
// Depends on akf_pkg.
`default_nettype none
module akf_mul (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [akf_pkg::DW-1:0] a,
  input  wire logic [akf_pkg::DW-1:0] b,
  output logic                        done,
  output logic      [akf_pkg::DW-1:0] y
);
  localparam int DW = akf_pkg::DW;
  localparam int HW = akf_pkg::HW;
  localparam int PW = akf_pkg::PW;
  localparam int FB = akf_pkg::FB;

  logic [DW-1:0] ua, ub;
  logic          neg;
  logic [PW-1:0] acc;
  logic [2:0]    cnt;
  logic          busy;

  logic [HW-1:0]   opa, opb;
  logic [2*HW-1:0] pp;
  logic [PW-1:0]   pp_sh;
  logic [PW-FB-1:0] m;
  logic [PW-FB-1:0] lim;
  logic [PW-FB-1:0] m_sat;
  logic [DW-1:0]   mag_a, mag_b;

  always_comb begin
    mag_a = a[DW-1] ? DW'(0) - a : a;
    mag_b = b[DW-1] ? DW'(0) - b : b;
    opa   = cnt[1] ? ua[DW-1:HW] : ua[HW-1:0];
    opb   = cnt[0] ? ub[DW-1:HW] : ub[HW-1:0];
    pp    = opa * opb;
    pp_sh = PW'(pp) << (HW * (32'(cnt[1]) + 32'(cnt[0])));
    m     = acc[PW-1:FB];
    lim   = neg ? (PW-FB)'(akf_pkg::MAXV) + (PW-FB)'(1) : (PW-FB)'(akf_pkg::MAXV);
    m_sat = (m > lim) ? lim : m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ua  <= mag_a;
      ub  <= mag_b;
      neg <= a[DW-1] ^ b[DW-1];
      // seed with the rounding half so the final step only shifts
      acc <= PW'(1) << (FB - 1);
    end else if (busy) begin
      if (cnt == 3'd4) begin
        y <= neg ? DW'(0) - m_sat[DW-1:0] : m_sat[DW-1:0];
      end else begin
        acc <= acc + pp_sh;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/akf_div.sv
// Restoring divider, one quotient bit per cycle: (|num| << FB) / den,
// rounded to nearest and saturated, den assumed positive.
// Depends on akf_pkg.
`default_nettype none
module akf_div (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [akf_pkg::DW-1:0] num,
  input  wire logic [akf_pkg::DW-1:0] den,
  output logic                        done,
  output logic      [akf_pkg::DW-1:0] y
);
  localparam int DW = akf_pkg::DW;
  localparam int FB = akf_pkg::FB;
  localparam int NW = akf_pkg::NW;
  localparam int CW = $clog2(NW + 3);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_STEP = 2'd1;
  localparam logic [1:0] D_RND  = 2'd2;
  localparam logic [1:0] D_SAT  = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] cnt;
  logic [NW-1:0] nq;
  logic [DW:0]   rem;
  logic [DW-1:0] d;
  logic          neg;
  logic [NW:0]   q;

  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW-1:0] mag_n;
  logic [NW:0]   lim;
  logic [NW:0]   q_sat;

  always_comb begin
    mag_n  = num[DW-1] ? DW'(0) - num : num;
    rem_sh = {rem[DW-1:0], nq[NW-1]};
    ge     = rem_sh >= {1'b0, d};
    lim    = neg ? (NW+1)'(akf_pkg::MAXV) + (NW+1)'(1) : (NW+1)'(akf_pkg::MAXV);
    q_sat  = (q > lim) ? lim : q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            state <= D_STEP;
            cnt   <= '0;
          end
        end
        D_STEP: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(NW - 1)) state <= D_RND;
        end
        D_RND: state <= D_SAT;
        D_SAT: begin
          state <= D_IDLE;
          done  <= 1'b1;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      D_IDLE: begin
        if (start) begin
          nq  <= NW'(mag_n) << FB;
          rem <= '0;
          d   <= den;
          neg <= num[DW-1];
        end
      end
      D_STEP: begin
        rem <= ge ? rem_sh - {1'b0, d} : rem_sh;
        nq  <= {nq[NW-2:0], ge};
      end
      D_RND: begin
        // round up when the remainder is at least half the divisor
        q <= {1'b0, nq} + (NW+1)'(rem >= ({1'b0, d} - rem));
      end
      D_SAT: y <= neg ? DW'(0) - q_sat[DW-1:0] : q_sat[DW-1:0];
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/angle_gyro_kalman_fusion_top.sv
// Top level of the two-state angle/gyro Kalman fusion block: config port,
// micro-op sequencer, state registers. Uses akf_pkg, akf_alu, akf_mul, akf_div.
`default_nettype none
// One sample runs a fixed program of 30 micro-ops: 18 saturating add/subtract
// steps, 10 multiplies on one iterative multiplier and 2 divides on one
// bit-serial divider. The time from acceptance to result is dominated by the
// two gain divisions; in_stall stays high for that time and drops with the
// result, so a new sample is taken only after the last one is through. When
// r_angle + cov_00 is not positive the divides are skipped. A finished result
// waits in the output register while the next sample is taken; a held-off
// result stalls the next sample at its end. All data is signed Q16.32 in 48
// bits with saturation; gains are forced to zero when r_angle + cov_00 is not
// positive. Registers sit at byte addresses 0, 8, 16, 24 on a 64-bit APB port.
module angle_gyro_kalman_fusion_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [47:0] accel_angle,
  input  wire logic [47:0] gyro_rate,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [47:0] angle_estimate,
  output logic      [47:0] corrected_rate
);
  localparam int DW = akf_pkg::DW;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [46:0] q_angle, q_gyro, r_angle;
  logic [32:0] step_time;

  logic [DW-1:0] angle_state, bias_state, cov_00, cov_01, cov_10, cov_11;
  logic [DW-1:0] acc_r, gyr_r, t_r, s_r, u_r, k0_r, k1_r, e_r, err_r, rate_r;

  logic [1:0]              state;
  logic [akf_pkg::PC_W-1:0] pc;
  akf_pkg::uop_t           uop;

  logic [DW-1:0] opa, opb, alu_y, mul_y, div_y, wdata;
  logic          wen;
  logic          mul_start, mul_done, div_start, div_done;
  logic          den_pos;
  logic          cfg_wr;

  function automatic logic [DW-1:0] pick(input logic [4:0] sel,
      input logic [DW-1:0] angle_v, input logic [DW-1:0] bias_v,
      input logic [DW-1:0] c00, input logic [DW-1:0] c01,
      input logic [DW-1:0] c10, input logic [DW-1:0] c11,
      input logic [DW-1:0] acc_v, input logic [DW-1:0] gyr_v,
      input logic [DW-1:0] t_v, input logic [DW-1:0] s_v,
      input logic [DW-1:0] u_v, input logic [DW-1:0] k0_v,
      input logic [DW-1:0] k1_v, input logic [DW-1:0] e_v,
      input logic [DW-1:0] err_v, input logic [DW-1:0] rate_v,
      input logic [DW-1:0] qa_v, input logic [DW-1:0] qg_v,
      input logic [DW-1:0] ra_v, input logic [DW-1:0] dt_v);
    logic [DW-1:0] v;
    case (sel)
      akf_pkg::R_ANGLE: v = angle_v;
      akf_pkg::R_BIAS:  v = bias_v;
      akf_pkg::R_C00:   v = c00;
      akf_pkg::R_C01:   v = c01;
      akf_pkg::R_C10:   v = c10;
      akf_pkg::R_C11:   v = c11;
      akf_pkg::R_ACC:   v = acc_v;
      akf_pkg::R_GYR:   v = gyr_v;
      akf_pkg::R_T:     v = t_v;
      akf_pkg::R_S:     v = s_v;
      akf_pkg::R_U:     v = u_v;
      akf_pkg::R_K0:    v = k0_v;
      akf_pkg::R_K1:    v = k1_v;
      akf_pkg::R_E:     v = e_v;
      akf_pkg::R_ERR:   v = err_v;
      akf_pkg::R_RATE:  v = rate_v;
      akf_pkg::R_QA:    v = qa_v;
      akf_pkg::R_QG:    v = qg_v;
      akf_pkg::R_RA:    v = ra_v;
      akf_pkg::R_DT:    v = dt_v;
      default:          v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    uop = akf_pkg::prog(pc);
    opa = pick(uop.src_a, angle_state, bias_state, cov_00, cov_01, cov_10, cov_11,
               acc_r, gyr_r, t_r, s_r, u_r, k0_r, k1_r, e_r, err_r, rate_r,
               DW'(q_angle), DW'(q_gyro), DW'(r_angle), DW'(step_time));
    opb = pick(uop.src_b, angle_state, bias_state, cov_00, cov_01, cov_10, cov_11,
               acc_r, gyr_r, t_r, s_r, u_r, k0_r, k1_r, e_r, err_r, rate_r,
               DW'(q_angle), DW'(q_gyro), DW'(r_angle), DW'(step_time));
    den_pos   = !opb[DW-1] && (opb != '0);
    mul_start = (state == S_ISSUE) && (uop.op == akf_pkg::OP_MUL);
    div_start = (state == S_ISSUE) && (uop.op == akf_pkg::OP_DIV) && den_pos;
    wen   = 1'b0;
    wdata = alu_y;
    if (state == S_ISSUE) begin
      if (uop.op == akf_pkg::OP_ADD || uop.op == akf_pkg::OP_SUB) begin
        wen = 1'b1;
      end else if (uop.op == akf_pkg::OP_DIV && !den_pos) begin
        // zero gain for a non-positive innovation variance
        wen   = 1'b1;
        wdata = '0;
      end
    end else if (state == S_WAIT && (mul_done || div_done)) begin
      wen   = 1'b1;
      wdata = mul_done ? mul_y : div_y;
    end
  end

  akf_alu u_alu (
    .a   (opa),
    .b   (opb),
    .sub (uop.op == akf_pkg::OP_SUB),
    .y   (alu_y)
  );

  akf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (opa),
    .b     (opb),
    .done  (mul_done),
    .y     (mul_y)
  );

  akf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (opa),
    .den   (opb),
    .done  (div_done),
    .y     (div_y)
  );

  assign in_stall = (state != S_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;

  always_comb begin
    case (paddr[4:3])
      akf_pkg::REG_Q_ANGLE:   prdata = 64'(q_angle);
      akf_pkg::REG_Q_GYRO:    prdata = 64'(q_gyro);
      akf_pkg::REG_R_ANGLE:   prdata = 64'(r_angle);
      akf_pkg::REG_STEP_TIME: prdata = 64'(step_time);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_angle   <= akf_pkg::Q_ANGLE_RST;
      q_gyro    <= akf_pkg::Q_GYRO_RST;
      r_angle   <= akf_pkg::R_ANGLE_RST;
      step_time <= akf_pkg::STEP_TIME_RST;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        akf_pkg::REG_Q_ANGLE:   q_angle   <= pwdata[46:0];
        akf_pkg::REG_Q_GYRO:    q_gyro    <= pwdata[46:0];
        akf_pkg::REG_R_ANGLE:   r_angle   <= pwdata[46:0];
        akf_pkg::REG_STEP_TIME: step_time <= pwdata[32:0];
        default: ;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_ISSUE;
            pc    <= '0;
          end
        end
        S_ISSUE: begin
          if (uop.op == akf_pkg::OP_END) begin
            state <= S_OUT;
          end else if (mul_start || div_start) begin
            state <= S_WAIT;
          end else begin
            pc <= pc + akf_pkg::PC_W'(1);
          end
        end
        S_WAIT: begin
          if (mul_done || div_done) begin
            state <= S_ISSUE;
            pc    <= pc + akf_pkg::PC_W'(1);
          end
        end
        S_OUT: begin
          // hold until the previous transaction has left
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      acc_r <= accel_angle;
      gyr_r <= gyro_rate;
    end
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      angle_estimate <= angle_state;
      corrected_rate <= rate_r;
    end
    if (wen) begin
      case (uop.dst)
        akf_pkg::R_T:    t_r    <= wdata;
        akf_pkg::R_S:    s_r    <= wdata;
        akf_pkg::R_U:    u_r    <= wdata;
        akf_pkg::R_K0:   k0_r   <= wdata;
        akf_pkg::R_K1:   k1_r   <= wdata;
        akf_pkg::R_E:    e_r    <= wdata;
        akf_pkg::R_ERR:  err_r  <= wdata;
        akf_pkg::R_RATE: rate_r <= wdata;
        default: ;
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_state <= '0;
      bias_state  <= '0;
      cov_00      <= akf_pkg::ONE;
      cov_01      <= '0;
      cov_10      <= '0;
      cov_11      <= akf_pkg::ONE;
    end else if (wen) begin
      case (uop.dst)
        akf_pkg::R_ANGLE: angle_state <= wdata;
        akf_pkg::R_BIAS:  bias_state  <= wdata;
        akf_pkg::R_C00:   cov_00      <= wdata;
        akf_pkg::R_C01:   cov_01      <= wdata;
        akf_pkg::R_C10:   cov_10      <= wdata;
        akf_pkg::R_C11:   cov_11      <= wdata;
        default: ;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("sequencer did not start on accepted transaction");

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_done && div_done))
    else $error("multiplier and divider finished together");

  a_done_only_waiting: assert property (@(posedge clk) disable iff (rst)
    (mul_done || div_done) |-> (state == S_WAIT))
    else $error("unit result arrived outside wait state");

  a_out_at_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (pc == akf_pkg::PC_LAST))
    else $error("result issued before program end");

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for angle_gyro_kalman_fusion_top: drives IMU samples
// and APB register writes, predicts angle and corrected rate. Uses akf_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SMAX = (64'sd1 <<< 47) - 1;
  localparam longint SMIN = -(64'sd1 <<< 47);
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int N_RANDOM = 600;

  typedef struct {
    longint ang;
    longint rate;
  } est_t;

  typedef struct {
    logic [47:0] acc;
    logic [47:0] gyr;
    bit          typed;
    longint      ang;
    longint      rate;
  } row_t;

  logic        clk, rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid, in_stall;
  logic [47:0] accel_angle, gyro_rate;
  logic        out_valid, out_stall;
  logic [47:0] angle_estimate, corrected_rate;

  // filter model state and register copies
  longint qa, qg, ra, dt;
  longint ang_s, bias_s, c00, c01, c10, c11;

  est_t   pending_est[$];
  int     mismatches;
  int     samples_in;
  longint cycles;
  row_t   rows[$];

  angle_gyro_kalman_fusion_top u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .accel_angle(accel_angle), .gyro_rate(gyro_rate),
    .out_valid(out_valid), .out_stall(out_stall),
    .angle_estimate(angle_estimate), .corrected_rate(corrected_rate)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic longint clamp(longint x);
    if (x > SMAX) return SMAX;
    if (x < SMIN) return SMIN;
    return x;
  endfunction

  function automatic longint sat_add(longint a, longint b);
    return clamp(a + b);
  endfunction

  function automatic longint sat_sub(longint a, longint b);
    return clamp(a - b);
  endfunction

  function automatic logic [127:0] magn(longint x);
    return (x < 0) ? 128'(-x) : 128'(x);
  endfunction

  // apply sign to a magnitude, saturating
  function automatic longint signed_of(bit neg, logic [127:0] m);
    logic [127:0] lim;
    lim = neg ? 128'(64'd1 << 47) : 128'(SMAX);
    if (m > lim) m = lim;
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint q_mul(longint a, longint b);
    logic [127:0] p;
    p = magn(a) * magn(b);
    p = (p + (128'd1 << (akf_pkg::FB - 1))) >> akf_pkg::FB;
    return signed_of((a < 0) != (b < 0), p);
  endfunction

  // den must be positive
  function automatic longint q_div(longint num, longint den);
    logic [127:0] n, d, q, r;
    n = magn(num) << akf_pkg::FB;
    d = 128'(den);
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 1;
    return signed_of(num < 0, q);
  endfunction

  function automatic void fuse_sample(logic [47:0] acc_in, logic [47:0] gyr_in,
                                      output est_t e);
    longint acc, gyr, p11dt, den, k0, k1, err, t0, t1;
    acc = longint'($signed(acc_in));
    gyr = longint'($signed(gyr_in));
    k0 = 0;
    k1 = 0;
    ang_s = sat_add(ang_s, q_mul(sat_sub(gyr, bias_s), dt));
    p11dt = q_mul(c11, dt);
    c00 = sat_add(c00, sat_add(sat_sub(qa, q_mul(sat_add(c01, c10), dt)),
                               q_mul(p11dt, dt)));
    c01 = sat_sub(c01, p11dt);
    c10 = sat_sub(c10, p11dt);
    c11 = sat_add(c11, qg);
    den = sat_add(ra, c00);
    // gains stay zero when the innovation variance is not positive
    if (den > 0) begin
      k0 = q_div(c00, den);
      k1 = q_div(c10, den);
    end
    err = sat_sub(acc, ang_s);
    ang_s = sat_add(ang_s, q_mul(k0, err));
    bias_s = sat_add(bias_s, q_mul(k1, err));
    e.ang = ang_s;
    e.rate = sat_sub(gyr, bias_s);
    t0 = c00;
    t1 = c01;
    c00 = sat_sub(c00, q_mul(k0, t0));
    c01 = sat_sub(c01, q_mul(k0, t1));
    c10 = sat_sub(c10, q_mul(k1, t0));
    c11 = sat_sub(c11, q_mul(k1, t1));
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    longint v;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 3'b000};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    v = (idx == akf_pkg::REG_STEP_TIME) ? longint'(val[32:0]) : longint'(val[46:0]);
    if (v > SMAX) v = SMAX;
    case (idx)
      akf_pkg::REG_Q_ANGLE:   qa = v;
      akf_pkg::REG_Q_GYRO:    qg = v;
      akf_pkg::REG_R_ANGLE:   ra = v;
      akf_pkg::REG_STEP_TIME: dt = v;
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_all(logic [63:0] a, logic [63:0] g, logic [63:0] r, logic [63:0] s);
    write_reg(akf_pkg::REG_Q_ANGLE, a);
    write_reg(akf_pkg::REG_Q_GYRO, g);
    write_reg(akf_pkg::REG_R_ANGLE, r);
    write_reg(akf_pkg::REG_STEP_TIME, s);
  endtask

  // one input transaction; typed rows override the predicted result
  task automatic send_sample(logic [47:0] acc, logic [47:0] gyr, bit typed,
                             longint ea, longint er);
    est_t e;
    int   gap;
    gap = 0;
    case ($urandom_range(0, 9))
      0, 1, 2: gap = $urandom_range(1, 4);
      3:       gap = $urandom_range(20, 120);
      default: gap = 0;
    endcase
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    accel_angle = acc;
    gyro_rate = gyr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fuse_sample(acc, gyr, e);
    if (typed) begin
      e.ang = ea;
      e.rate = er;
    end
    pending_est.push_back(e);
    samples_in++;
  endtask

  function automatic logic [47:0] rand_field();
    case ($urandom_range(0, 9))
      0:       return 48'({$urandom, $urandom});
      1:       return ($urandom_range(0, 1) != 0) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
      default: return 48'($signed({$urandom_range(0, 15), $urandom}) - 64'sd34359738368);
    endcase
  endfunction

  // drop valid so the last transaction is not taken twice, then wait for results
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    @(posedge clk);
    while (pending_est.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    repeat (n) send_sample(rand_field(), rand_field(), 1'b0, 0, 0);
    drain();
  endtask

  // result checker
  always @(posedge clk) begin
    est_t   e;
    longint ga, gr;
    if (!rst && out_valid && !out_stall) begin
      ga = longint'($signed(angle_estimate));
      gr = longint'($signed(corrected_rate));
      if (pending_est.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result angle=%0d rate=%0d", ga, gr);
      end else begin
        e = pending_est.pop_front();
        if (e.ang != ga || e.rate != gr) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: angle exp %0d got %0d, rate exp %0d got %0d",
                     e.ang, ga, e.rate, gr);
        end
      end
    end
  end

  // output back-pressure, with one long hold-off once traffic is flowing
  initial begin
    bit long_done;
    int n;
    long_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_done && samples_in >= 150) begin
        long_done = 1'b1;
        out_stall = 1'b1;
        repeat (3000) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        n = $urandom_range(0, 9);
        out_stall = (n >= 6);
        if (n < 6) repeat ($urandom_range(0, 30)) @(negedge clk);
        else if (n < 9) repeat ($urandom_range(0, 4)) @(negedge clk);
        else repeat ($urandom_range(20, 400)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    mismatches = 0;
    samples_in = 0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    accel_angle = '0;
    gyro_rate = '0;
    qa = longint'(akf_pkg::Q_ANGLE_RST);
    qg = longint'(akf_pkg::Q_GYRO_RST);
    ra = longint'(akf_pkg::R_ANGLE_RST);
    dt = longint'(akf_pkg::STEP_TIME_RST);
    ang_s = 0;
    bias_s = 0;
    c00 = longint'(akf_pkg::ONE);
    c01 = 0;
    c10 = 0;
    c11 = longint'(akf_pkg::ONE);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero samples from reset keep angle and rate at zero; then extreme and mixed field values
    rows.push_back('{48'h0, 48'h0, 1'b1, 0, 0});
    rows.push_back('{48'h0, 48'h0, 1'b1, 0, 0});
    rows.push_back('{48'h7FFF_FFFF_FFFF, 48'h0, 1'b0, 0, 0});
    rows.push_back('{48'h8000_0000_0000, 48'h0, 1'b0, 0, 0});
    rows.push_back('{48'h0, 48'h7FFF_FFFF_FFFF, 1'b0, 0, 0});
    rows.push_back('{48'h0, 48'h8000_0000_0000, 1'b0, 0, 0});
    rows.push_back('{48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 1'b0, 0, 0});
    rows.push_back('{48'h8000_0000_0000, 48'h8000_0000_0000, 1'b0, 0, 0});
    rows.push_back('{48'h0000_0000_0001, 48'hFFFF_FFFF_FFFF, 1'b0, 0, 0});
    rows.push_back('{48'h0001_0000_0000, 48'h0000_8000_0000, 1'b0, 0, 0});
    rows.push_back('{48'hFFFF_0000_0000, 48'h0002_0000_0000, 1'b0, 0, 0});
    rows.push_back('{48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 1'b0, 0, 0});
    foreach (rows[i]) send_sample(rows[i].acc, rows[i].gyr, rows[i].typed,
                                  rows[i].ang, rows[i].rate);
    drain();

    // smallest settings: no process noise, tiny dt and r
    set_all(64'd0, 64'd0, 64'd1, 64'd1);
    repeat (6) send_sample(rand_field(), rand_field(), 1'b0, 0, 0);
    drain();
    random_phase(N_RANDOM / 6);

    // realistic random settings
    set_all($urandom_range(0, 1 << 24), $urandom_range(0, 1 << 26),
            $urandom_range(1, 1 << 31), $urandom_range(1, 1 << 25));
    random_phase(N_RANDOM / 3);

    // largest settings, registers keep only the bits of their widths
    set_all('1, '1, '1, '1);
    random_phase(N_RANDOM / 6);

    // arbitrary register contents
    set_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
            {$urandom, $urandom});
    random_phase(N_RANDOM / 12);

    set_all(64'd429497, 64'd12884902, 64'd429496730, 64'd4294967);
    random_phase(N_RANDOM / 4);

    in_valid = 1'b0;
    repeat (400) @(posedge clk);
    if (mismatches == 0 && pending_est.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
